// ===== src/pfrs_pkg.sv =====
// ----------------------------------------------------------------------------
// pfrs_pkg
// Shared types for the prime factor range sieve.
// ----------------------------------------------------------------------------
package pfrs_pkg;

  localparam int unsigned ValueWidth = 16;

  typedef enum logic [1:0] {
    CLS_NORMAL = 2'd0,
    CLS_ONE    = 2'd1,
    CLS_BAD    = 2'd2
  } class_e;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    class_e                cls;
  } item_t;

endpackage

// ===== src/prime_factor_range_sieve.sv =====
// ----------------------------------------------------------------------------
// prime_factor_range_sieve
// Smallest and largest distinct prime factor of a value via a sieve table.
// ----------------------------------------------------------------------------
// Command channel: a value beat is taken on a clock edge with start_i high
// and busy_o low. One result beat per value appears on the result ports for
// a single cycle with valid_o high; the receiver cannot stall it.
// After reset busy_o stays high while the table is cleared and then
// sieved, with at most one table write per cycle.
// A two-entry queue sits between command acceptance and the factoring
// engine, so up to two values may wait while one is being factored.
// Zero, out-of-range values and the value one give their result from the
// queue head through the registered result outputs. Other values pass
// through the queue, then per distinct prime a table read (S_READ, S_LOOK)
// and a trial division by that prime on the shift-subtract divider, repeated
// while it divides, with one extra non-dividing trial for every prime but
// the last.
// ----------------------------------------------------------------------------
module prime_factor_range_sieve #(
  parameter int unsigned TABLE_SIZE = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] value_i,
  output logic        busy_o,
  output logic        valid_o,
  output logic [15:0] smallest_prime_o,
  output logic [15:0] largest_prime_o,
  output logic        single_prime_o,
  output logic        bad_value_o
);
  import pfrs_pkg::*;

  item_t f_item;
  item_t q_item;
  logic  push;
  logic  full;
  logic  empty;
  logic  pop;
  logic  ready;

  pfrs_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
    .start_i (start_i),
    .value_i (value_i),
    .ready_i (ready),
    .full_i  (full),
    .busy_o  (busy_o),
    .push_o  (push),
    .item_o  (f_item)
  );

  pfrs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .item_o  (q_item)
  );

  pfrs_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .item_i           (q_item),
    .pop_o            (pop),
    .ready_o          (ready),
    .valid_o          (valid_o),
    .smallest_prime_o (smallest_prime_o),
    .largest_prime_o  (largest_prime_o),
    .single_prime_o   (single_prime_o),
    .bad_value_o      (bad_value_o)
  );

endmodule

// ===== src/pfrs_front.sv =====
// ----------------------------------------------------------------------------
// pfrs_front
// Accepts commands and sorts each value into normal, one or out of range.
// ----------------------------------------------------------------------------
module pfrs_front #(
  parameter int unsigned TABLE_SIZE = 65536
) (
  input  logic                  start_i,
  input  logic [15:0]           value_i,
  input  logic                  ready_i,
  input  logic                  full_i,
  output logic                  busy_o,
  output logic                  push_o,
  output pfrs_pkg::item_t       item_o
);
  import pfrs_pkg::*;

  assign busy_o = !ready_i || full_i;
  assign push_o = start_i && !busy_o;

  always_comb begin
    item_o.value = value_i;
    if ((value_i == '0) || (32'(value_i) >= 32'(TABLE_SIZE))) begin
      item_o.cls = CLS_BAD;
    end else if (value_i == 16'd1) begin
      item_o.cls = CLS_ONE;
    end else begin
      item_o.cls = CLS_NORMAL;
    end
  end

endmodule

// ===== src/pfrs_fifo.sv =====
// ----------------------------------------------------------------------------
// pfrs_fifo
// Two-entry queue between the command front and the factoring engine.
// ----------------------------------------------------------------------------
module pfrs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pfrs_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output pfrs_pkg::item_t item_o
);
  import pfrs_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== src/pfrs_back.sv =====
// ----------------------------------------------------------------------------
// pfrs_back
// Sieve fill of the smallest-prime-factor table and the factoring engine.
// ----------------------------------------------------------------------------
module pfrs_back #(
  parameter int unsigned TABLE_SIZE = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  pfrs_pkg::item_t item_i,
  output logic            pop_o,
  output logic            ready_o,
  output logic            valid_o,
  output logic [15:0]     smallest_prime_o,
  output logic [15:0]     largest_prime_o,
  output logic            single_prime_o,
  output logic            bad_value_o
);
  import pfrs_pkg::*;

  function automatic int unsigned isqrt_below(int unsigned ts);
    int unsigned r;
    r = 2;
    for (int unsigned k = 2; k * k < ts; k++) begin
      r = k;
    end
    return r;
  endfunction

  localparam int unsigned AW    = $clog2(TABLE_SIZE);
  localparam int unsigned IMax  = isqrt_below(TABLE_SIZE);
  localparam int unsigned IW    = $clog2(IMax + 1);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_SIEVE_I = 3'd1;
  localparam logic [2:0] S_SIEVE_J = 3'd2;
  localparam logic [2:0] S_IDLE    = 3'd3;
  localparam logic [2:0] S_READ    = 3'd4;
  localparam logic [2:0] S_LOOK    = 3'd5;
  localparam logic [2:0] S_DIV     = 3'd6;

  logic [15:0]   mem [TABLE_SIZE];
  logic [15:0]   rdata_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;

  logic [2:0]    state_q;
  logic [AW-1:0] clr_q;
  logic [IW-1:0] i_q;
  logic [AW:0]   j_q;
  logic [AW:0]   j_d;
  logic          ready_q;

  logic [15:0]   n_q;
  logic [15:0]   p_q;
  logic [15:0]   p_d;
  logic [15:0]   lo_q;
  logic [15:0]   hi_q;
  logic          single_q;
  logic          first_q;
  logic [15:0]   rem_q;
  logic [15:0]   quo_q;
  logic [3:0]    cnt_q;
  logic [16:0]   rem_sh;
  logic          ge;
  logic [15:0]   rem_d;
  logic [15:0]   quo_d;

  logic          valid_q;
  logic [15:0]   small_q;
  logic [15:0]   large_q;
  logic          sp_q;
  logic          bad_q;

  assign ready_o          = ready_q;
  assign valid_o          = valid_q;
  assign smallest_prime_o = small_q;
  assign largest_prime_o  = large_q;
  assign single_prime_o   = sp_q;
  assign bad_value_o      = bad_q;
  assign pop_o            = (state_q == S_IDLE) && !empty_i;

  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    if (state_q == S_CLEAR) begin
      we = 1'b1;
    end else if (state_q == S_SIEVE_J) begin
      we    = 1'b1;
      waddr = j_q[AW-1:0];
      wdata = 16'(i_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[AW'(n_q)];
  end

  assign j_d    = j_q + (AW+1)'(i_q);
  assign p_d    = (rdata_q != '0) ? rdata_q : n_q;
  assign rem_sh = {rem_q, quo_q[15]};
  assign ge     = rem_sh >= {1'b0, p_q};
  assign rem_d  = ge ? 16'(rem_sh - {1'b0, p_q}) : rem_sh[15:0];
  assign quo_d  = {quo_q[14:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      i_q      <= IW'(IMax);
      j_q      <= '0;
      ready_q  <= 1'b0;
      valid_q  <= 1'b0;
      n_q      <= '0;
      p_q      <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      single_q <= 1'b0;
      first_q  <= 1'b0;
      rem_q    <= '0;
      quo_q    <= '0;
      cnt_q    <= '0;
      small_q  <= '0;
      large_q  <= '0;
      sp_q     <= 1'b0;
      bad_q    <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(TABLE_SIZE - 1)) begin
            state_q <= S_SIEVE_I;
          end
        end
        S_SIEVE_I: begin
          j_q     <= (AW+1)'(i_q) * (AW+1)'(i_q);
          state_q <= S_SIEVE_J;
        end
        S_SIEVE_J: begin
          j_q <= j_d;
          if (j_d >= (AW+1)'(TABLE_SIZE)) begin
            if (i_q == IW'(2)) begin
              ready_q <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q - IW'(1);
              state_q <= S_SIEVE_I;
            end
          end
        end
        S_IDLE: begin
          if (!empty_i) begin
            case (item_i.cls)
              CLS_BAD: begin
                valid_q <= 1'b1;
                small_q <= '0;
                large_q <= '0;
                sp_q    <= 1'b0;
                bad_q   <= 1'b1;
              end
              CLS_ONE: begin
                valid_q <= 1'b1;
                small_q <= '0;
                large_q <= '0;
                sp_q    <= 1'b1;
                bad_q   <= 1'b0;
              end
              default: begin
                n_q      <= item_i.value;
                first_q  <= 1'b1;
                single_q <= 1'b1;
                state_q  <= S_READ;
              end
            endcase
          end
        end
        S_READ: begin
          state_q <= S_LOOK;
        end
        S_LOOK: begin
          p_q     <= p_d;
          first_q <= 1'b0;
          if (first_q) begin
            lo_q <= p_d;
            hi_q <= p_d;
          end else begin
            if (p_d != lo_q) begin
              single_q <= 1'b0;
            end
            if (p_d > hi_q) begin
              hi_q <= p_d;
            end
            if (p_d < lo_q) begin
              lo_q <= p_d;
            end
          end
          rem_q   <= '0;
          quo_q   <= n_q;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            if (rem_d == '0) begin
              n_q <= quo_d;
              if (quo_d == 16'd1) begin
                valid_q <= 1'b1;
                small_q <= lo_q;
                large_q <= hi_q;
                sp_q    <= single_q;
                bad_q   <= 1'b0;
                state_q <= S_IDLE;
              end else begin
                rem_q <= '0;
                cnt_q <= '0;
              end
            end else begin
              state_q <= S_READ;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
